// ===== rtl/siicw_pkg.sv =====
// siicw_pkg: shared types, codes and helper functions of the SII EEPROM category walker.
// Depends on nothing. It is used by siicw_step, siicw_rslt_q and sii_eeprom_category_walker.
`default_nettype none

package siicw_pkg;

    // walk phase, one-hot
    typedef enum logic [4:0] {
        PH_HEAD = 5'b00001,
        PH_TYPE = 5'b00010,
        PH_SIZE = 5'b00100,
        PH_DATA = 5'b01000,
        PH_DONE = 5'b10000
    } t_phase;

    typedef enum logic [2:0] {
        K_CONFIG   = 3'd0,
        K_IDENTITY = 3'd1,
        K_MAILBOX  = 3'd2,
        K_SIZEVER  = 3'd3,
        K_HEADER   = 3'd4,
        K_DATA     = 3'd5,
        K_DONE     = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        C_END_MARK = 2'd0,
        C_BLANK    = 2'd1,
        C_SIZE     = 2'd2,
        C_LIMIT    = 2'd3
    } t_cause;

    // category type codes
    localparam logic [15:0] TY_STRINGS  = 16'd10;
    localparam logic [15:0] TY_GENERAL  = 16'd30;
    localparam logic [15:0] TY_FMMU     = 16'd40;
    localparam logic [15:0] TY_SYNCMGR  = 16'd41;
    localparam logic [15:0] TY_TXPDO    = 16'd50;
    localparam logic [15:0] TY_RXPDO    = 16'd51;
    localparam logic [15:0] TY_DC       = 16'd60;
    localparam logic [15:0] TY_END      = 16'hFFFF;

    localparam logic [7:0]  CRC_POLY    = 8'h07;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [15:0] CFG_LAST    = 16'd7;
    localparam logic [15:0] ID_FIRST    = 16'h0008;
    localparam logic [15:0] ID_END      = 16'd16;
    localparam logic [15:0] MBX_FIRST   = 16'h0014;
    localparam logic [15:0] MBX_LAST    = 16'h001C;
    localparam int          SIZE_SHIFT  = 6;   // size byte counts 64-word units

    localparam int          Q_DEPTH     = 4;
    localparam int          Q_AW        = 2;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] word_count;
        logic [7:0]  crc_acc;
        logic        crc_match;
        logic [15:0] pair_low;
        logic [15:0] next_hdr;
        logic [6:0]  cat_total;
        logic [15:0] cur_type;
        logic [15:0] cur_size;
        logic [15:0] data_off;
        logic        cur_wanted;
        logic [7:0]  eep_size;   // zero: unbounded
    } t_state;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] addr;
        logic [31:0] value;
        logic        chk;
        logic [15:0] ctype;
        logic [15:0] coff;
        logic        wanted;
        t_cause      cause;
        logic        last;
    } t_rec;

    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    function automatic logic type_wanted(input logic [15:0] ctype, input logic [6:0] mask);
        logic [6:0] m;
        logic       r;
        m = mask;
        if (m[1] || m[4] || m[5]) begin
            m[0] = 1'b1;
        end
        unique case (ctype)
            TY_STRINGS: r = m[0];
            TY_GENERAL: r = m[1];
            TY_FMMU:    r = m[2];
            TY_SYNCMGR: r = m[3];
            TY_TXPDO:   r = m[4];
            TY_RXPDO:   r = m[5];
            TY_DC:      r = m[6];
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic t_rec make_rec(input t_kind kind, input logic [15:0] addr,
                                      input logic [31:0] value, input logic [15:0] ctype,
                                      input logic [15:0] coff, input logic wanted,
                                      input t_cause cause);
        t_rec r;
        r.kind   = kind;
        r.addr   = addr;
        r.value  = value;
        r.chk    = 1'b0;
        r.ctype  = ctype;
        r.coff   = coff;
        r.wanted = wanted;
        r.cause  = cause;
        r.last   = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/siicw_step.sv =====
// siicw_step: next-state and record logic for one EEPROM word.
// Depends on siicw_pkg. Purely combinational; the state registers live in the top level.
`default_nettype none

module siicw_step #(
    parameter int CATEGORY_START = 64,
    parameter int CAT_LIMIT      = 64,
    parameter int SIZE_WORD_ADDR = 62
) (
    input  siicw_pkg::t_state i_state,
    input  logic [15:0]       i_word,
    input  logic [6:0]        i_mask,
    output siicw_pkg::t_state o_state,
    output logic [1:0]        o_rec_cnt,
    output siicw_pkg::t_rec   o_rec0,
    output siicw_pkg::t_rec   o_rec1
);
    import siicw_pkg::*;

    t_state      ns;
    t_rec        p_rec;
    t_rec        d_rec;
    logic        p_v;
    logic        d_v;
    logic        do_stop;
    logic [15:0] addr;
    logic [15:0] w;
    logic [15:0] nxt_off;
    logic [15:0] size_words;

    always_comb begin
        ns         = i_state;
        addr       = i_state.word_count;
        w          = i_word;
        p_v        = 1'b0;
        d_v        = 1'b0;
        do_stop    = 1'b0;
        p_rec      = make_rec(K_CONFIG, addr, 32'd0, 16'd0, 16'd0, 1'b0, C_END_MARK);
        d_rec      = make_rec(K_DONE, addr, 32'd0, 16'd0, 16'd0, 1'b0, C_END_MARK);
        nxt_off    = i_state.data_off + 16'd1;
        size_words = 16'd0;

        if (i_state.phase != PH_DONE) begin
            ns.word_count = i_state.word_count + 16'd1;
        end

        unique case (i_state.phase)
            PH_HEAD: begin
                priority if (addr < CFG_LAST) begin
                    ns.crc_acc = crc_byte(crc_byte(i_state.crc_acc, w[7:0]), w[15:8]);
                    p_v   = 1'b1;
                    p_rec = make_rec(K_CONFIG, addr, {16'd0, w}, 16'd0, 16'd0, 1'b0,
                                     C_END_MARK);
                end else if (addr == CFG_LAST) begin
                    ns.crc_match = (i_state.crc_acc == w[7:0]);
                    p_v   = 1'b1;
                    p_rec = make_rec(K_CONFIG, addr, {16'd0, w}, 16'd0, 16'd0, 1'b0,
                                     C_END_MARK);
                end else if (addr < ID_END) begin
                    if (!addr[0]) begin
                        ns.pair_low = w;
                    end else begin
                        p_v   = 1'b1;
                        p_rec = make_rec(K_IDENTITY, addr, {w, i_state.pair_low}, 16'd0,
                                         16'd0, 1'b0, C_END_MARK);
                    end
                end else if (addr >= MBX_FIRST && addr <= MBX_LAST) begin
                    p_v   = 1'b1;
                    p_rec = make_rec(K_MAILBOX, addr, {16'd0, w}, 16'd0, 16'd0, 1'b0,
                                     C_END_MARK);
                end else if (addr == 16'(SIZE_WORD_ADDR)) begin
                    ns.eep_size = w[7:0];
                    p_v   = 1'b1;
                    p_rec = make_rec(K_SIZEVER, addr, {16'd0, w}, 16'd0, 16'd0, 1'b0,
                                     C_END_MARK);
                end else if (addr == 16'(SIZE_WORD_ADDR + 1)) begin
                    p_v   = 1'b1;
                    p_rec = make_rec(K_SIZEVER, addr, {16'd0, w}, 16'd0, 16'd0, 1'b0,
                                     C_END_MARK);
                end else begin
                    p_v = 1'b0;
                end
                // last header-area word: first header address becomes known
                if (({1'b0, addr} + 17'd1) >= 17'(CATEGORY_START)) begin
                    do_stop = 1'b1;
                end
            end
            PH_TYPE: begin
                ns.cur_type = w;
                ns.phase    = PH_SIZE;
            end
            PH_SIZE: begin
                ns.cur_size = w;
                priority if (i_state.cur_type == TY_END) begin
                    ns.phase    = PH_DONE;
                    d_v         = 1'b1;
                    d_rec.cause = C_END_MARK;
                end else if (i_state.cur_type == 16'd0 && w == 16'd0) begin
                    ns.phase    = PH_DONE;
                    d_v         = 1'b1;
                    d_rec.cause = C_BLANK;
                end else begin
                    ns.cur_wanted = type_wanted(i_state.cur_type, i_mask);
                    ns.data_off   = 16'd0;
                    p_v   = 1'b1;
                    p_rec = make_rec(K_HEADER, addr, {16'd0, w}, i_state.cur_type, w,
                                     ns.cur_wanted, C_END_MARK);
                    if (w == 16'd0) begin
                        ns.next_hdr  = i_state.next_hdr + 16'd2 + w;
                        ns.cat_total = i_state.cat_total + 7'd1;
                        do_stop      = 1'b1;
                    end else begin
                        ns.phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (i_state.cur_wanted) begin
                    p_v   = 1'b1;
                    p_rec = make_rec(K_DATA, addr, {16'd0, w}, i_state.cur_type,
                                     i_state.data_off, 1'b1, C_END_MARK);
                end
                ns.data_off = nxt_off;
                if (nxt_off >= i_state.cur_size) begin
                    ns.next_hdr  = i_state.next_hdr + 16'd2 + i_state.cur_size;
                    ns.cat_total = i_state.cat_total + 7'd1;
                    do_stop      = 1'b1;
                end
            end
            PH_DONE: begin
                ns = i_state;
            end
            default: begin
                ns = i_state;
            end
        endcase

        size_words = {2'b00, ns.eep_size, 6'd0};
        if (do_stop) begin
            priority if (ns.cat_total >= 7'(CAT_LIMIT)) begin
                ns.phase    = PH_DONE;
                d_v         = 1'b1;
                d_rec.cause = C_LIMIT;
            end else if (ns.eep_size != 8'd0 && ns.next_hdr >= size_words) begin
                ns.phase    = PH_DONE;
                d_v         = 1'b1;
                d_rec.cause = C_SIZE;
            end else begin
                ns.phase = PH_TYPE;
            end
        end

        p_rec.chk = ns.crc_match;
        d_rec.chk = ns.crc_match;
    end

    // primary record first, done record after it
    always_comb begin
        o_state   = ns;
        o_rec_cnt = {1'b0, p_v} + {1'b0, d_v};
        o_rec0    = p_v ? p_rec : d_rec;
        o_rec1    = d_rec;
        o_rec0.last = (p_v ^ d_v);
        o_rec1.last = 1'b1;
    end

endmodule

`default_nettype wire

// ===== rtl/siicw_rslt_q.sv =====
// siicw_rslt_q: four-entry result queue, takes up to two records a cycle, gives one.
// Depends on siicw_pkg.
`default_nettype none

module siicw_rslt_q (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [1:0]      i_push_cnt,
    input  siicw_pkg::t_rec i_rec0,
    input  siicw_pkg::t_rec i_rec1,
    input  logic            i_pop,
    output logic            o_valid,
    output logic            o_room2,
    output siicw_pkg::t_rec o_rec
);
    import siicw_pkg::*;

    localparam int CW = Q_AW + 1;

    t_rec          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, n_wp;
    logic [Q_AW-1:0] r_rp, n_rp;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            pop_ok;

    assign pop_ok  = i_pop && (r_cnt != '0);
    assign o_valid = (r_cnt != '0);
    assign o_room2 = (r_cnt <= CW'(Q_DEPTH - 2));
    assign o_rec   = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp + Q_AW'(i_push_cnt);
        n_rp  = r_rp + Q_AW'(pop_ok);
        n_cnt = r_cnt + CW'(i_push_cnt) - CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wp] <= i_rec0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[r_wp + Q_AW'(1)] <= i_rec1;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sii_eeprom_category_walker.sv =====
// sii_eeprom_category_walker: top level; input register, walk state, mask register.
// Depends on siicw_pkg, siicw_step and siicw_rslt_q.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------
//  in      | sink      | i_in_valid/o_in_stall  | i_eeprom_word
//  out     | source    | o_out_valid/i_out_stall| o_rec_kind .. o_last_of_run
//  cfg     | sink      | i_cfg_valid/o_cfg_ready| i_category_mask
//
// One EEPROM word a cycle: a beat lands in the input register, and from there
// the step logic updates the walk state and pushes zero, one or two records into
// a four-entry result queue. A word is processed only while the queue has room
// for two records.
// Reset (i_rst_n low, synchronous) clears the state to the header phase at word 0,
// CRC 0xFF, mask 127, and empties both the input register and the queue.
// A stall on the output fills the queue; the input stalls once the queue has
// fewer than two free entries and a word is waiting.
`default_nettype none

module sii_eeprom_category_walker #(
    parameter int CATEGORY_START = 64,
    parameter int CAT_LIMIT      = 64,
    parameter int SIZE_WORD_ADDR = 62
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_category_mask,
    // EEPROM words
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_eeprom_word,
    // result records
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_rec_kind,
    output logic [15:0] o_word_addr,
    output logic [31:0] o_rec_value,
    output logic        o_crc_ok,
    output logic [15:0] o_category_type,
    output logic [15:0] o_category_offset,
    output logic        o_wanted,
    output logic [1:0]  o_end_cause,
    output logic        o_last_of_run
);
    import siicw_pkg::*;

    logic        r_iv;
    logic [15:0] r_iw;
    logic [6:0]  r_mask;
    t_state      r_state, n_state;
    t_state      step_state;
    logic [1:0]  step_cnt;
    t_rec        step_rec0;
    t_rec        step_rec1;
    t_rec        q_rec;
    logic        q_room2;
    logic        fire;
    logic        in_take;
    t_state      rst_state;

    // a word waiting in the input register is processed when two queue slots are free
    assign fire        = r_iv && q_room2;
    assign o_in_stall  = r_iv && !q_room2;
    assign in_take     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        rst_state            = '0;
        rst_state.phase      = PH_HEAD;
        rst_state.crc_acc    = CRC_INIT;
        rst_state.next_hdr   = 16'(CATEGORY_START);
        n_state              = fire ? step_state : r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv    <= 1'b0;
            r_mask  <= 7'h7F;
            r_state <= rst_state;
        end else begin
            if (in_take) begin
                r_iv <= 1'b1;
            end else if (fire) begin
                r_iv <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_category_mask;
            end
            r_state <= n_state;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_iw <= i_eeprom_word;
        end
    end

    siicw_step #(
        .CATEGORY_START (CATEGORY_START),
        .CAT_LIMIT      (CAT_LIMIT),
        .SIZE_WORD_ADDR (SIZE_WORD_ADDR)
    ) u_step (
        .i_state   (r_state),
        .i_word    (r_iw),
        .i_mask    (r_mask),
        .o_state   (step_state),
        .o_rec_cnt (step_cnt),
        .o_rec0    (step_rec0),
        .o_rec1    (step_rec1)
    );

    siicw_rslt_q u_q (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (fire ? step_cnt : 2'd0),
        .i_rec0     (step_rec0),
        .i_rec1     (step_rec1),
        .i_pop      (!i_out_stall),
        .o_valid    (o_out_valid),
        .o_room2    (q_room2),
        .o_rec      (q_rec)
    );

    assign o_rec_kind        = q_rec.kind;
    assign o_word_addr       = q_rec.addr;
    assign o_rec_value       = q_rec.value;
    assign o_crc_ok          = q_rec.chk;
    assign o_category_type   = q_rec.ctype;
    assign o_category_offset = q_rec.coff;
    assign o_wanted          = q_rec.wanted;
    assign o_end_cause       = q_rec.cause;
    assign o_last_of_run     = q_rec.last;

    // once the walk is done it never restarts
    a_done_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_DONE |=> r_state.phase == PH_DONE)
        else $error("walk left the done phase");

    // a step that queues a done record leaves the walk done
    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && step_cnt != 2'd0 &&
        ((step_cnt == 2'd1 && step_rec0.kind == K_DONE) ||
         (step_cnt == 2'd2 && step_rec1.kind == K_DONE))
        |=> r_state.phase == PH_DONE)
        else $error("done record without done phase");

    // the word counter only moves with a processed word
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !fire |=> $stable(r_state.word_count))
        else $error("word counter moved without a word");

endmodule

`default_nettype wire
